// ===== src/lfu_cache_policy_defines.svh =====
// Assertion macros for the LFU cache policy block.
`ifndef LFU_CACHE_POLICY_DEFINES_SVH
`define LFU_CACHE_POLICY_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LFU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfu_cache_policy: check failed");

// Next-cycle implication, disabled in reset.
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfu_cache_policy: check failed");

`endif

// ===== src/lfu_pkg.sv =====
// Constants, types and codes of the LFU cache policy block.
`timescale 1ns / 1ps
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int FREQ_BITS  = 16;
  localparam int VALUE_BITS = 32;
  localparam int STAMP_BITS = 32;
  localparam int CAP_BITS   = 5;
  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_BITS   = $clog2(ENTRIES + 1);
  localparam int CNT_BITS   = IDX_BITS + 1;

  localparam logic [FREQ_BITS-1:0] FREQ_MAX = '1;
  localparam logic [CAP_BITS-1:0]  CAP_RESET = CAP_BITS'(16);

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [FREQ_BITS-1:0]  freq;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ===== src/lfu_ram.sv =====
// Simple dual-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module lfu_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lfu_cache_policy.sv =====
// Top level of the LFU cache policy block: scan sequencer, entry RAM and result register.
//
// Key/value cache with least-frequently-used replacement, ties broken by oldest stamp.
// Input channel (in_valid/in_ready) carries action (0 get, 1 put), key and value.
// Output channel (out_valid/out_ready) carries found and read_value, one result per item.
// Configuration: cfg_we with cfg_data writes the capacity register at once; write it
// only while the block is idle.
// Each item reads every entry of the entry RAM once through its single read port,
// and a new item is taken the cycle after the previous one has written back.
// One item is in work at a time; in_ready is high only between items.
// The result sits in an output register; the next item is accepted while it waits.
// If the receiver stalls, the following item finishes its scan and holds before
// write-back until the output register frees.
// Synchronous reset clears all valid bits, occupancy and the time counter and sets
// capacity to 16; the RAM contents are not cleared, there is no clearing pass.
`timescale 1ns / 1ps
`include "lfu_cache_policy_defines.svh"
module lfu_cache_policy (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lfu_pkg::CAP_BITS-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic signed [31:0]                key,
  input  logic signed [31:0]                value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic signed [31:0]                read_value
);

  lfu_pkg::state_t state, state_next;

  logic [lfu_pkg::CAP_BITS-1:0]   capacity;
  logic [lfu_pkg::ENTRIES-1:0]    valid;
  logic [lfu_pkg::ENTRIES-1:0]    valid_next;
  logic [lfu_pkg::OCC_BITS-1:0]   occupancy;
  logic [lfu_pkg::STAMP_BITS-1:0] time_counter;

  logic                           act;
  logic [lfu_pkg::KEY_BITS-1:0]   key_r;
  logic [lfu_pkg::VALUE_BITS-1:0] value_r;

  logic [lfu_pkg::CNT_BITS-1:0]   issue_cnt;
  logic                           pend;
  logic [lfu_pkg::IDX_BITS-1:0]   pidx;

  logic                           hit;
  logic [lfu_pkg::IDX_BITS-1:0]   hit_idx;
  logic [lfu_pkg::VALUE_BITS-1:0] hit_value;
  logic [lfu_pkg::FREQ_BITS-1:0]  hit_freq;

  logic                           vic_have;
  logic [lfu_pkg::IDX_BITS-1:0]   vic_idx;
  logic [lfu_pkg::FREQ_BITS-1:0]  vic_freq;
  logic [lfu_pkg::STAMP_BITS-1:0] vic_stamp;

  logic                           free_have;
  logic [lfu_pkg::IDX_BITS-1:0]   free_idx;

  logic                           ram_we;
  logic [lfu_pkg::IDX_BITS-1:0]   ram_waddr;
  lfu_pkg::entry_t                ram_wentry;
  logic                           ram_re;
  logic [lfu_pkg::ENTRY_BITS-1:0] ram_rdata;
  lfu_pkg::entry_t                rd;

  logic                           in_xfer;
  logic                           advance;
  logic                           scan_done;
  logic [31:0]                    cap_eff;
  logic [lfu_pkg::FREQ_BITS-1:0]  freq_inc;
  logic                           do_touch;
  logic                           do_evict;
  logic                           do_insert;
  logic [lfu_pkg::IDX_BITS-1:0]   slot;
  logic                           res_found;
  logic [31:0]                    res_value;

  lfu_ram #(
    .WIDTH     (lfu_pkg::ENTRY_BITS),
    .DEPTH     (lfu_pkg::ENTRIES),
    .ADDR_BITS (lfu_pkg::IDX_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (issue_cnt[lfu_pkg::IDX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  assign rd        = lfu_pkg::entry_t'(ram_rdata);
  assign in_ready  = (state == lfu_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign ram_re    = (state == lfu_pkg::ST_SCAN) &&
                     (issue_cnt < lfu_pkg::CNT_BITS'(lfu_pkg::ENTRIES));
  assign scan_done = (issue_cnt == lfu_pkg::CNT_BITS'(lfu_pkg::ENTRIES)) && !pend;
  assign advance   = (state == lfu_pkg::ST_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = lfu_pkg::ST_FINISH;
        end
      end
      lfu_pkg::ST_FINISH: begin
        if (advance) begin
          state_next = lfu_pkg::ST_IDLE;
        end
      end
      default: state_next = lfu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfu_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // scan: issue one read a cycle, examine the returned entry in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      pend      <= 1'b0;
    end else if (in_xfer) begin
      issue_cnt <= '0;
      pend      <= 1'b0;
    end else if (state == lfu_pkg::ST_SCAN) begin
      pend <= ram_re;
      if (ram_re) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act       <= action;
      key_r     <= key[lfu_pkg::KEY_BITS-1:0];
      value_r   <= value;
      hit       <= 1'b0;
      vic_have  <= 1'b0;
      free_have <= 1'b0;
    end else if (state == lfu_pkg::ST_SCAN) begin
      pidx <= issue_cnt[lfu_pkg::IDX_BITS-1:0];
      if (pend) begin
        if (valid[pidx]) begin
          if (!hit && rd.key == key_r) begin
            hit       <= 1'b1;
            hit_idx   <= pidx;
            hit_value <= rd.value;
            hit_freq  <= rd.freq;
          end
          if (!vic_have || rd.freq < vic_freq ||
              (rd.freq == vic_freq && rd.stamp < vic_stamp)) begin
            vic_have  <= 1'b1;
            vic_idx   <= pidx;
            vic_freq  <= rd.freq;
            vic_stamp <= rd.stamp;
          end
        end else if (!free_have) begin
          free_have <= 1'b1;
          free_idx  <= pidx;
        end
      end
    end
  end

  // decide the write-back from the scan summary
  always_comb begin
    cap_eff   = (32'(capacity) > 32'(lfu_pkg::ENTRIES)) ? 32'(lfu_pkg::ENTRIES)
                                                         : 32'(capacity);
    freq_inc  = (hit_freq == lfu_pkg::FREQ_MAX) ? hit_freq : hit_freq + 1'b1;
    do_touch  = 1'b0;
    do_evict  = 1'b0;
    do_insert = 1'b0;
    slot      = free_idx;
    ram_we    = 1'b0;
    ram_waddr = hit_idx;
    ram_wentry.key   = key_r;
    ram_wentry.value = hit_value;
    ram_wentry.freq  = freq_inc;
    ram_wentry.stamp = time_counter;
    res_found = hit;
    res_value = '0;
    if (act == lfu_pkg::ACT_GET) begin
      if (hit) begin
        res_value = hit_value;
        do_touch  = 1'b1;
      end else begin
        res_value = '1;
      end
    end else if (cap_eff != '0) begin
      if (hit) begin
        ram_wentry.value = value_r;
        do_touch = 1'b1;
      end else begin
        do_evict = (32'(occupancy) >= cap_eff) && vic_have;
        if (do_evict && (!free_have || vic_idx < free_idx)) begin
          slot      = vic_idx;
          do_insert = 1'b1;
        end else begin
          slot      = free_idx;
          do_insert = free_have;
        end
        ram_waddr        = slot;
        ram_wentry.value = value_r;
        ram_wentry.freq  = lfu_pkg::FREQ_BITS'(1);
      end
    end
    ram_we = advance && (do_touch || do_insert);
  end

  always_comb begin
    valid_next = valid;
    if (do_evict) begin
      valid_next[vic_idx] = 1'b0;
    end
    if (do_insert) begin
      valid_next[slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      occupancy    <= '0;
      time_counter <= '0;
    end else if (advance) begin
      if (do_touch || do_insert) begin
        time_counter <= time_counter + 1'b1;
      end
      valid <= valid_next;
      if (do_insert && !do_evict) begin
        occupancy <= occupancy + 1'b1;
      end else if (do_evict && !do_insert) begin
        occupancy <= occupancy - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      found      <= res_found;
      read_value <= res_value;
    end
  end

  `LFU_ASSERT_IMPL(a_occ_matches_valid, clk, rst, 1'b1, $countones(valid) == 32'(occupancy))
  `LFU_ASSERT_NEXT(a_finish_loads_result, clk, rst, advance, out_valid)
  `LFU_ASSERT_NEXT(a_accept_starts_scan, clk, rst, in_xfer,
    (state == lfu_pkg::ST_SCAN) && (issue_cnt == '0) && !hit)

endmodule
